[rtl/gas_pkg.sv]
// Shared types and constants for the greedy activity selection block.
package gas_pkg;

  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_FLUSH
  } gas_state_t;

  typedef struct packed {
    logic load;
    logic walk;
  } cell_ctl_t;

endpackage

[rtl/gas_cell.sv]
// One sorting cell: holds one activity and moves it to a neighbor on insert or walk.
module gas_cell #(
  parameter int TIME_BITS = 16
) (
  input  logic                   clk,
  input  gas_pkg::cell_ctl_t     ctl,
  input  logic                   occupied,
  input  logic [TIME_BITS-1:0]   new_start,
  input  logic [TIME_BITS-1:0]   new_finish,
  input  logic [gas_pkg::IDX_W-1:0] new_idx,
  input  logic                   left_shift,
  input  logic [TIME_BITS-1:0]   left_start,
  input  logic [TIME_BITS-1:0]   left_finish,
  input  logic [gas_pkg::IDX_W-1:0] left_idx,
  input  logic [TIME_BITS-1:0]   right_start,
  input  logic [TIME_BITS-1:0]   right_finish,
  input  logic [gas_pkg::IDX_W-1:0] right_idx,
  output logic                   shift,
  output logic [TIME_BITS-1:0]   start_q,
  output logic [TIME_BITS-1:0]   finish_q,
  output logic [gas_pkg::IDX_W-1:0] idx_q
);
  import gas_pkg::*;

  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] finish_r, finish_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  assign shift = occupied && (finish_r > new_finish);

  always_comb begin
    start_nxt  = start_r;
    finish_nxt = finish_r;
    idx_nxt    = idx_r;
    if (ctl.walk) begin
      start_nxt  = right_start;
      finish_nxt = right_finish;
      idx_nxt    = right_idx;
    end else if (ctl.load) begin
      if (left_shift) begin
        start_nxt  = left_start;
        finish_nxt = left_finish;
        idx_nxt    = left_idx;
      end else if (shift || !occupied) begin
        start_nxt  = new_start;
        finish_nxt = new_finish;
        idx_nxt    = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    finish_r <= finish_nxt;
    idx_r    <= idx_nxt;
  end

  assign start_q  = start_r;
  assign finish_q = finish_r;
  assign idx_q    = idx_r;

endmodule

[rtl/greedy_activity_selection.sv]
// Top level of the greedy activity selection block: cell row, control and result register.
//
//   channel | ports                                         | handshake
//   input   | in_start_time, in_finish_time, in_is_last     | start high, busy low
//   result  | out_chosen_index, out_final_choice, out_overflow | out_valid, one cycle
//
// Each word loads into the sorted cell row with busy low; words past a full row are dropped.
// After the closing word the row shifts toward cell zero once per cycle, and busy stays
// high through the walk and the flush state that follows it while the results come out.
// Each result waits in a pending register, so the last one can carry its final mark.
// Reset clears the fill count, the drop flag and the control; the receiver cannot stall.
module greedy_activity_selection #(
  parameter int MAX_ACTIVITIES = 32,
  parameter int TIME_BITS      = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [TIME_BITS-1:0]       in_start_time,
  input  logic [TIME_BITS-1:0]       in_finish_time,
  input  logic                       in_is_last,
  output logic                       out_valid,
  output logic [gas_pkg::IDX_W-1:0]  out_chosen_index,
  output logic                       out_final_choice,
  output logic                       out_overflow
);
  import gas_pkg::*;

  localparam int CNT_W = $clog2(MAX_ACTIVITIES + 1);

  gas_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic dropped_r, dropped_nxt;
  logic ovf_r, ovf_nxt;
  logic first_r, first_nxt;
  logic [TIME_BITS-1:0] last_fin_r, last_fin_nxt;
  logic pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic out_fin_r, out_fin_nxt;
  logic out_ovf_r, out_ovf_nxt;

  logic accept;
  logic room;
  cell_ctl_t ctl;
  logic [IDX_W-1:0] new_idx;
  logic chosen;

  logic [TIME_BITS-1:0] st [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] fn [MAX_ACTIVITIES];
  logic [IDX_W-1:0]     ix [MAX_ACTIVITIES];
  logic                 sh [MAX_ACTIVITIES];

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;
  assign room   = (count_r < CNT_W'(MAX_ACTIVITIES));
  assign new_idx = IDX_W'(count_r + CNT_W'(1));
  assign ctl.load = accept && room;
  assign ctl.walk = (state_r == ST_WALK);

  for (genvar i = 0; i < MAX_ACTIVITIES; i++) begin : g_cell
    logic                 l_shift;
    logic [TIME_BITS-1:0] l_start, l_finish, r_start, r_finish;
    logic [IDX_W-1:0]     l_idx, r_idx;

    if (i == 0) begin : g_left_edge
      assign l_shift  = 1'b0;
      assign l_start  = '0;
      assign l_finish = '0;
      assign l_idx    = '0;
    end else begin : g_left
      assign l_shift  = sh[i-1];
      assign l_start  = st[i-1];
      assign l_finish = fn[i-1];
      assign l_idx    = ix[i-1];
    end

    if (i == MAX_ACTIVITIES - 1) begin : g_right_edge
      assign r_start  = '0;
      assign r_finish = '0;
      assign r_idx    = '0;
    end else begin : g_right
      assign r_start  = st[i+1];
      assign r_finish = fn[i+1];
      assign r_idx    = ix[i+1];
    end

    gas_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occupied     (CNT_W'(i) < count_r),
      .new_start    (in_start_time),
      .new_finish   (in_finish_time),
      .new_idx      (new_idx),
      .left_shift   (l_shift),
      .left_start   (l_start),
      .left_finish  (l_finish),
      .left_idx     (l_idx),
      .right_start  (r_start),
      .right_finish (r_finish),
      .right_idx    (r_idx),
      .shift        (sh[i]),
      .start_q      (st[i]),
      .finish_q     (fn[i]),
      .idx_q        (ix[i])
    );
  end

  // Next state, fill count and walk counter.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    dropped_nxt = dropped_r;
    ovf_nxt     = ovf_r;
    first_nxt   = first_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_is_last) begin
            rem_nxt   = count_nxt;
            ovf_nxt   = dropped_nxt;
            first_nxt = 1'b1;
            state_nxt = (count_nxt == '0) ? ST_FLUSH : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rem_nxt   = rem_r - CNT_W'(1);
        first_nxt = 1'b0;
        if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        count_nxt   = '0;
        dropped_nxt = 1'b0;
        state_nxt   = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Selection and result words; a chosen activity waits until the next one is known.
  always_comb begin
    chosen         = first_r || (st[0] >= last_fin_r);
    last_fin_nxt   = last_fin_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = pend_idx_r;
    out_fin_nxt    = 1'b0;
    out_ovf_nxt    = ovf_r;
    case (state_r)
      ST_WALK: begin
        if (chosen) begin
          last_fin_nxt   = fn[0];
          out_valid_nxt  = pend_valid_r;
          pend_valid_nxt = 1'b1;
          pend_idx_nxt   = ix[0];
        end
      end
      ST_FLUSH: begin
        out_valid_nxt  = pend_valid_r;
        out_fin_nxt    = 1'b1;
        pend_valid_nxt = 1'b0;
      end
      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      rem_r        <= '0;
      dropped_r    <= 1'b0;
      ovf_r        <= 1'b0;
      first_r      <= 1'b0;
      last_fin_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rem_r        <= rem_nxt;
      dropped_r    <= dropped_nxt;
      ovf_r        <= ovf_nxt;
      first_r      <= first_nxt;
      last_fin_r   <= last_fin_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_fin_r  <= out_fin_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign out_final_choice = out_fin_r;
  assign out_overflow     = out_ovf_r;

`ifndef SYNTHESIS
  a_final_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_choice |=> !out_valid)
    else $error("Result word followed the final choice.");

  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_is_last |=> busy)
    else $error("Closing word did not start the walk.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ACTIVITIES))
    else $error("Fill count exceeds the cell row.");

  a_walk_emits_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> rem_r != '0)
    else $error("Walk running with nothing left.");
`endif

endmodule

[verif/tb_greedy_activity_selection.sv]
// Testbench for greedy_activity_selection: directed table and random sets against a predictor.
module tb_greedy_activity_selection;
  timeunit 1ns;
  timeprecision 1ps;

  import gas_pkg::*;

  localparam int SLOTS        = 32;
  localparam int TW           = 16;
  localparam int RANDOM_WORDS = 430;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int N_ROWS       = 18;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fin;
    logic             ovf;
  } pick_t;

  typedef struct {
    logic [TW-1:0] s;
    logic [TW-1:0] f;
    bit            last;
    int            reps;
    bit            typed;
    logic          t_ovf;
  } stim_row_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [TW-1:0]    in_start_time = '0;
  logic [TW-1:0]    in_finish_time = '0;
  logic             in_is_last = 1'b0;
  logic             out_valid;
  logic [IDX_W-1:0] out_chosen_index;
  logic             out_final_choice;
  logic             out_overflow;

  logic [TW-1:0]    sched_start [SLOTS];
  logic [TW-1:0]    sched_finish [SLOTS];
  logic [IDX_W-1:0] sched_pos [SLOTS];
  int               sched_count = 0;
  logic             sched_dropped = 1'b0;

  pick_t            expected_picks [$];
  int               errors = 0;
  int               cycles = 0;
  int               burst_left = 0;
  stim_row_t        rows [N_ROWS];

  greedy_activity_selection #(
    .MAX_ACTIVITIES(SLOTS),
    .TIME_BITS(TW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_start_time(in_start_time),
    .in_finish_time(in_finish_time),
    .in_is_last(in_is_last),
    .out_valid(out_valid),
    .out_chosen_index(out_chosen_index),
    .out_final_choice(out_final_choice),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stim_row_t mk_row(input logic [TW-1:0] s, input logic [TW-1:0] f,
                                       input bit last, input int reps, input bit typed,
                                       input logic t_ovf);
    stim_row_t r;
    r.s = s;
    r.f = f;
    r.last = last;
    r.reps = reps;
    r.typed = typed;
    r.t_ovf = t_ovf;
    return r;
  endfunction

  // Stores one word in finish order and, on the closing word, walks the set.
  function automatic void schedule_word(input logic [TW-1:0] s, input logic [TW-1:0] f,
                                        input bit last, input bit keep);
    int            pos;
    logic [TW-1:0] lf;
    pick_t         walk [$];
    pick_t         p;
    if (sched_count < SLOTS) begin
      pos = sched_count;
      while (pos > 0 && sched_finish[pos-1] > f) begin
        sched_start[pos] = sched_start[pos-1];
        sched_finish[pos] = sched_finish[pos-1];
        sched_pos[pos] = sched_pos[pos-1];
        pos--;
      end
      sched_start[pos] = s;
      sched_finish[pos] = f;
      sched_pos[pos] = IDX_W'(sched_count + 1);
      sched_count++;
    end else begin
      sched_dropped = 1'b1;
    end
    if (!last) return;
    if (sched_count > 0) begin
      lf = sched_finish[0];
      p.idx = sched_pos[0];
      p.fin = 1'b0;
      p.ovf = sched_dropped;
      walk.push_back(p);
      for (int i = 1; i < sched_count; i++) begin
        if (sched_start[i] >= lf) begin
          p.idx = sched_pos[i];
          walk.push_back(p);
          lf = sched_finish[i];
        end
      end
      walk[walk.size()-1].fin = 1'b1;
      if (keep) begin
        foreach (walk[i]) expected_picks.push_back(walk[i]);
      end
    end
    sched_count = 0;
    sched_dropped = 1'b0;
  endfunction

  function automatic logic [TW-1:0] edge_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return TW'(1);
      3: return TW'(16'h8000);
      4: return TW'(16'h7FFF);
      default: return TW'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [TW-1:0] s, input logic [TW-1:0] f, input bit last,
                           input bit keep, input bit drain);
    in_start_time <= s;
    in_finish_time <= f;
    in_is_last <= last;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    schedule_word(s, f, last, keep);
    if (drain) begin
      start <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clk);
    end else begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  initial begin
    pick_t         p;
    int            sent;
    int            size;
    int            mode;
    int            r;
    logic [TW-1:0] s;
    logic [TW-1:0] f;
    logic [TW-1:0] tmp;

    rows[0]  = mk_row(16'h0000, 16'h0000, 1, 1, 1, 1'b0);
    rows[1]  = mk_row(16'hFFFF, 16'hFFFF, 1, 1, 1, 1'b0);
    rows[2]  = mk_row(16'hFFFF, 16'h0000, 1, 1, 1, 1'b0);
    rows[3]  = mk_row(16'h0000, 16'hFFFF, 1, 1, 1, 1'b0);
    rows[4]  = mk_row(16'd1, 16'd4, 0, 1, 0, 1'b0);
    rows[5]  = mk_row(16'd3, 16'd5, 0, 1, 0, 1'b0);
    rows[6]  = mk_row(16'd0, 16'd6, 0, 1, 0, 1'b0);
    rows[7]  = mk_row(16'd5, 16'd7, 0, 1, 0, 1'b0);
    rows[8]  = mk_row(16'd8, 16'd9, 0, 1, 0, 1'b0);
    rows[9]  = mk_row(16'd5, 16'd9, 1, 1, 0, 1'b0);
    rows[10] = mk_row(16'd5, 16'd10, 0, 1, 0, 1'b0);
    rows[11] = mk_row(16'd0, 16'd10, 0, 1, 0, 1'b0);
    rows[12] = mk_row(16'd10, 16'd10, 1, 1, 0, 1'b0);
    rows[13] = mk_row(16'd0, 16'd5, 0, 1, 0, 1'b0);
    rows[14] = mk_row(16'd5, 16'd8, 0, 1, 0, 1'b0);
    rows[15] = mk_row(16'd4, 16'd8, 1, 1, 0, 1'b0);
    rows[16] = mk_row(16'd10, 16'd20, 0, SLOTS, 0, 1'b0);
    rows[17] = mk_row(16'd0, 16'd5, 1, 1, 1, 1'b1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (rows[i].typed) begin
        p.idx = IDX_W'(1);
        p.fin = 1'b1;
        p.ovf = rows[i].t_ovf;
        expected_picks.push_back(p);
      end
      for (int k = 0; k < rows[i].reps; k++) begin
        send_word(rows[i].s, rows[i].f, rows[i].last, !rows[i].typed, i == N_ROWS - 1);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      size = (r < 65) ? $urandom_range(1, 6) :
             (r < 90) ? $urandom_range(7, SLOTS) : $urandom_range(SLOTS + 1, SLOTS + 8);
      mode = $urandom_range(0, 2);
      for (int k = 0; k < size; k++) begin
        case (mode)
          0: begin
            s = TW'($urandom);
            f = TW'($urandom);
          end
          1: begin
            s = TW'($urandom_range(0, 60));
            f = s + TW'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0) begin
              tmp = s;
              s = f;
              f = tmp;
            end
          end
          default: begin
            s = edge_time();
            f = edge_time();
          end
        endcase
        send_word(s, f, k == size - 1, 1'b1, (k == size - 1) && (sent + 1 >= RANDOM_WORDS));
        sent++;
      end
    end

    repeat (2 * SLOTS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_valid) begin
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected word, expected none, got idx=%0d final=%0b ovf=%0b", $time,
                 out_chosen_index, out_final_choice, out_overflow);
        errors++;
      end else begin
        want = expected_picks.pop_front();
        if (want.idx !== out_chosen_index || want.fin !== out_final_choice ||
            want.ovf !== out_overflow) begin
          $display("%0t: mismatch expected idx=%0d final=%0b ovf=%0b,",
                   $time, want.idx, want.fin, want.ovf,
                   " got idx=%0d final=%0b ovf=%0b",
                   out_chosen_index, out_final_choice, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/gas_pkg.sv
rtl/gas_cell.sv
rtl/greedy_activity_selection.sv
verif/tb_greedy_activity_selection.sv
